### rtl/shkt_pkg.sv
// Package for the sorted hash key table: request/response structs and codes.
// Used by every module of the block; no dependencies.
package shkt_pkg;

	typedef struct packed {
		logic        req_type;
		logic [31:0] key_hash;
		logic [31:0] value_word;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [8:0]  slot_index;
		logic [31:0] found_value;
	} rsp_t;

	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_INSERT = 1'b1;

	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_UPDATED   = 3'd2;
	localparam logic [2:0] ST_INSERTED  = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_RD,
		BK_CMP,
		BK_SHRD,
		BK_SHWR,
		BK_PUT,
		BK_DONE
	} bk_state_t;

endpackage

### rtl/shkt_queue.sv
// Two-entry request queue between the front and back parts.
// Depends on shkt_pkg.
module shkt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  shkt_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_take,
	output shkt_pkg::req_t  out_data
);
	shkt_pkg::req_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push, pop;

	assign in_stall  = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rp_q];
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && out_take;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

### rtl/shkt_front.sv
// Front part: registers incoming requests and passes them on to the queue.
// Depends on shkt_pkg.
module shkt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  shkt_pkg::req_t  req,
	output logic            q_valid,
	input  logic            q_stall,
	output shkt_pkg::req_t  q_data
);
	shkt_pkg::req_t data_q;
	logic           valid_q;

	assign req_stall = valid_q && q_stall;
	assign q_valid   = valid_q;
	assign q_data    = data_q;

	always_ff @(posedge clk) begin
		if (!req_stall) begin
			data_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!req_stall) begin
			valid_q <= req_valid;
		end
	end
endmodule

### rtl/shkt_back.sv
// Back part: binary search and shift-insert over the hash and value memories,
// with a registered response. Depends on shkt_pkg.
module shkt_back #(
	parameter int CAPACITY = 512
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_take,
	input  shkt_pkg::req_t  q_data,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output shkt_pkg::rsp_t  rsp
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [31:0] hmem [CAPACITY];
	logic [31:0] vmem [CAPACITY];

	shkt_pkg::bk_state_t state_q, state_d;
	shkt_pkg::req_t      cur_q;
	logic [CW-1:0]       count_q, lo_q, hi_q, idx_q;
	logic [AW-1:0]       rd_addr, wr_addr;
	logic [31:0]         hrd_q, vrd_q, wr_h, wr_v;
	logic                hwe, vwe;
	logic [CW:0]         mid_sum;
	logic [CW-1:0]       mid;
	logic                full, take;
	shkt_pkg::rsp_t      rsp_q;
	logic                rsp_valid_q;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CW:1];
	assign full    = (count_q == CW'(CAPACITY));
	assign take    = (state_q == shkt_pkg::BK_IDLE) && q_valid && !rsp_valid_q;
	assign q_take  = take;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (hwe) begin
			hmem[wr_addr] <= wr_h;
		end
		if (vwe) begin
			vmem[wr_addr] <= wr_v;
		end
		hrd_q <= hmem[rd_addr];
		vrd_q <= vmem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			shkt_pkg::BK_IDLE: begin
				if (take) begin
					if (q_data.req_type == shkt_pkg::REQ_INSERT && full) begin
						state_d = shkt_pkg::BK_DONE;
					end else begin
						state_d = shkt_pkg::BK_RD;
					end
				end
			end
			shkt_pkg::BK_RD: begin
				if (lo_q < hi_q) begin
					state_d = shkt_pkg::BK_CMP;
				end else if (cur_q.req_type == shkt_pkg::REQ_INSERT) begin
					state_d = (idx_q > lo_q) ? shkt_pkg::BK_SHRD : shkt_pkg::BK_PUT;
				end else begin
					state_d = shkt_pkg::BK_DONE;
				end
			end
			shkt_pkg::BK_CMP: begin
				state_d = (hrd_q == cur_q.key_hash) ? shkt_pkg::BK_DONE
				                                    : shkt_pkg::BK_RD;
			end
			shkt_pkg::BK_SHRD: state_d = shkt_pkg::BK_SHWR;
			shkt_pkg::BK_SHWR: begin
				state_d = (idx_q - 1'b1 > lo_q) ? shkt_pkg::BK_SHRD : shkt_pkg::BK_PUT;
			end
			shkt_pkg::BK_PUT:  state_d = shkt_pkg::BK_DONE;
			shkt_pkg::BK_DONE: state_d = shkt_pkg::BK_IDLE;
			default:           state_d = shkt_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		rd_addr = mid[AW-1:0];
		wr_addr = idx_q[AW-1:0];
		wr_h    = hrd_q;
		wr_v    = vrd_q;
		hwe     = 1'b0;
		vwe     = 1'b0;
		case (state_q)
			shkt_pkg::BK_SHRD: begin
				rd_addr = AW'(idx_q - 1'b1);
			end
			shkt_pkg::BK_SHWR: begin
				hwe = 1'b1;
				vwe = 1'b1;
			end
			shkt_pkg::BK_PUT: begin
				wr_addr = lo_q[AW-1:0];
				wr_h    = cur_q.key_hash;
				wr_v    = cur_q.value_word;
				hwe     = 1'b1;
				vwe     = 1'b1;
			end
			shkt_pkg::BK_CMP: begin
				wr_addr = mid[AW-1:0];
				wr_v    = cur_q.value_word;
				vwe     = (hrd_q == cur_q.key_hash)
				          && (cur_q.req_type == shkt_pkg::REQ_INSERT);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			shkt_pkg::BK_IDLE: begin
				if (take) begin
					cur_q <= q_data;
					lo_q  <= '0;
					hi_q  <= count_q;
					idx_q <= count_q;
					rsp_q <= '{status: shkt_pkg::ST_FULL, slot_index: 9'd0,
					           found_value: 32'd0};
				end
			end
			shkt_pkg::BK_RD: begin
				if (!(lo_q < hi_q)) begin
					rsp_q.status <= (cur_q.req_type == shkt_pkg::REQ_INSERT)
					                ? shkt_pkg::ST_INSERTED : shkt_pkg::ST_NOT_FOUND;
					if (cur_q.req_type == shkt_pkg::REQ_INSERT) begin
						rsp_q.slot_index <= 9'(lo_q);
					end
				end
			end
			shkt_pkg::BK_CMP: begin
				if (hrd_q == cur_q.key_hash) begin
					rsp_q.slot_index <= 9'(mid);
					if (cur_q.req_type == shkt_pkg::REQ_INSERT) begin
						rsp_q.status <= shkt_pkg::ST_UPDATED;
					end else begin
						rsp_q.status      <= shkt_pkg::ST_FOUND;
						rsp_q.found_value <= vrd_q;
					end
				end else if (hrd_q > cur_q.key_hash) begin
					hi_q <= mid;
				end else begin
					lo_q <= mid + 1'b1;
				end
			end
			shkt_pkg::BK_SHWR: begin
				idx_q <= idx_q - 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= shkt_pkg::BK_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == shkt_pkg::BK_PUT) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == shkt_pkg::BK_DONE) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end
endmodule

### rtl/sorted_hash_key_table.sv
// Sorted hash key table, top level: front register, request queue, back engine.
// Depends on shkt_pkg, shkt_front, shkt_queue, shkt_back.
//
// Usage: requests enter on req_valid/req_stall/req (lookup or insert by
// 32-bit key hash); one response leaves per request on
// rsp_valid/rsp_stall/rsp with status, slot index and value.
// Steps from acceptance: a lookup runs a read state and a compare state per
// binary-search probe. An insert of a new hash then moves each later entry
// up one slot, reading and then writing the hash and value memories.
// An insert on a full table answers without searching.
// The back engine handles one request at a time; the front register and a
// two-entry queue keep accepting requests meanwhile.
// Reset empties the table; memory contents are not cleared, and only entries
// below the entry count are ever used. When the receiver stalls, the response holds
// and the engine takes no new request until it is delivered.
module sorted_hash_key_table #(
	parameter int CAPACITY = 512
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  shkt_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output shkt_pkg::rsp_t  rsp
);
	logic           f_valid, f_stall, b_valid, b_take;
	shkt_pkg::req_t f_data, b_data;

	shkt_front u_front (
		.clk, .arst_n, .req_valid, .req_stall, .req,
		.q_valid(f_valid), .q_stall(f_stall), .q_data(f_data)
	);

	shkt_queue u_queue (
		.clk, .arst_n, .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
		.out_valid(b_valid), .out_take(b_take), .out_data(b_data)
	);

	shkt_back #(.CAPACITY(CAPACITY)) u_back (
		.clk, .arst_n, .q_valid(b_valid), .q_take(b_take), .q_data(b_data),
		.rsp_valid, .rsp_stall, .rsp
	);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= shkt_pkg::ST_FULL)
		else $error("bad status code");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		b_take |-> b_valid && !rsp_valid)
		else $error("engine took request while busy");
endmodule

### tb/tb_top.sv
// Self-checking testbench for sorted_hash_key_table: drives lookups and inserts,
// predicts every response with a scoreboard and compares each one field by field.
// Depends on shkt_pkg and the sorted_hash_key_table RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 512;
	localparam int RANDOM_ITEMS = 1825;
	localparam longint CYCLE_LIMIT = 20000000;

	class table_scoreboard;
		logic [31:0] hashes[DEPTH];
		logic [31:0] values[DEPTH];
		int unsigned count;
		shkt_pkg::rsp_t pending[$];
		logic [31:0] keys[$];
		int errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		// note an accepted transaction and queue its expected response
		function void note(shkt_pkg::req_t r);
			shkt_pkg::rsp_t e;
			int lo, hi, mid, pos;
			bit hit;
			e = '0;
			hit = 0;
			pos = 0;
			lo = 0;
			hi = count;
			while (lo < hi && !hit) begin
				mid = (lo + hi) / 2;
				if (hashes[mid] == r.key_hash) begin
					hit = 1;
					pos = mid;
				end else if (hashes[mid] > r.key_hash) begin
					hi = mid;
				end else begin
					lo = mid + 1;
				end
			end
			if (r.req_type == shkt_pkg::REQ_LOOKUP) begin
				if (hit) begin
					e.status = shkt_pkg::ST_FOUND;
					e.slot_index = pos[8:0];
					e.found_value = values[pos];
				end else begin
					e.status = shkt_pkg::ST_NOT_FOUND;
				end
			end else if (count >= DEPTH) begin
				e.status = shkt_pkg::ST_FULL;
			end else if (hit) begin
				values[pos] = r.value_word;
				e.status = shkt_pkg::ST_UPDATED;
				e.slot_index = pos[8:0];
			end else begin
				// key absent: lo is the upper-bound position
				for (int i = count; i > lo; i--) begin
					hashes[i] = hashes[i-1];
					values[i] = values[i-1];
				end
				hashes[lo] = r.key_hash;
				values[lo] = r.value_word;
				count++;
				keys.push_back(r.key_hash);
				e.status = shkt_pkg::ST_INSERTED;
				e.slot_index = lo[8:0];
			end
			pending.push_back(e);
		endfunction

		function void check(shkt_pkg::rsp_t a);
			shkt_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected response %h", $time, a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
				errors++;
			end
			if (a.slot_index !== e.slot_index) begin
				$display("%0t: slot_index expected %0d actual %0d", $time,
					e.slot_index, a.slot_index);
				errors++;
			end
			if (a.found_value !== e.found_value) begin
				$display("%0t: found_value expected %h actual %h", $time,
					e.found_value, a.found_value);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	shkt_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	shkt_pkg::rsp_t rsp;
	longint cycles;
	table_scoreboard sb;

	sorted_hash_key_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		req_valid = 0;
		req = '0;
		rsp_stall = 0;
		cycles = 0;
		sb = new();
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check(rsp);
	end

	// receiver stall pattern: quiet stretches, random stalls, periodic stalls
	initial begin
		int mode, len;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			len = $urandom_range(20, 200);
			for (int i = 0; i < len; i++) begin
				@(negedge clk);
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 2) == 0);
					default: rsp_stall <= ((i % 4) == 3);
				endcase
			end
		end
	end

	task automatic send(input logic kind, input logic [31:0] key, input logic [31:0] val);
		shkt_pkg::req_t r;
		r.req_type = kind;
		r.key_hash = key;
		r.value_word = val;
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		sb.note(r);
		@(negedge clk);
	endtask

	task automatic pause(input int n);
		req_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_key(input int known_pct);
		logic [31:0] k;
		int roll;
		roll = $urandom_range(0, 99);
		if (sb.keys.size() > 0 && roll < known_pct) begin
			k = sb.keys[$urandom_range(0, sb.keys.size() - 1)];
			case ($urandom_range(0, 5))
				0: k = k + 1;
				1: k = k - 1;
				default: ;
			endcase
		end else if (roll < known_pct + 4) begin
			k = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		end else begin
			k = $urandom();
		end
		return k;
	endfunction

	initial begin
		int burst;
		logic kind;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send(shkt_pkg::REQ_LOOKUP, 32'h0, 32'h0);
		send(shkt_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(shkt_pkg::REQ_INSERT, 32'h8000_0000, 32'h1234_5678);
		send(shkt_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(shkt_pkg::REQ_INSERT, 32'h0, 32'h0);
		send(shkt_pkg::REQ_INSERT, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
		send(shkt_pkg::REQ_INSERT, 32'h8000_0001, 32'h5A5A_5A5A);
		send(shkt_pkg::REQ_LOOKUP, 32'h0, 32'h0);
		send(shkt_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		send(shkt_pkg::REQ_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF);
		send(shkt_pkg::REQ_LOOKUP, 32'h7FFF_FFFE, 32'h0);
		send(shkt_pkg::REQ_INSERT, 32'h8000_0000, 32'hDEAD_BEEF);
		send(shkt_pkg::REQ_INSERT, 32'h0, 32'hFFFF_FFFF);
		send(shkt_pkg::REQ_LOOKUP, 32'h8000_0000, 32'h0);
		send(shkt_pkg::REQ_LOOKUP, 32'h0, 32'h0);
		send(shkt_pkg::REQ_INSERT, 32'h0000_0001, 32'h0000_0001);
		send(shkt_pkg::REQ_INSERT, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
		send(shkt_pkg::REQ_LOOKUP, 32'hFFFF_FFFE, 32'h0);
		pause(3);

		for (int n = 0; n < RANDOM_ITEMS; ) begin
			burst = $urandom_range(1, 16);
			for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++) begin
				kind = ($urandom_range(0, 99) < 45) ? shkt_pkg::REQ_INSERT
				                                    : shkt_pkg::REQ_LOOKUP;
				if (kind == shkt_pkg::REQ_INSERT)
					send(kind, pick_key(25), $urandom());
				else
					send(kind, pick_key(65), $urandom());
			end
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 12));
		end
		req_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
